// ===== rtl/csvt_pkg.sv =====
// ---------------------------------------------------------------------------
// csvt_pkg: shared types and constants of the CSV byte tokenizer
// Character codes and the item and result records passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Input kinds carried on s_tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOT  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       field_end;
        logic       record_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/csvt_in_stage.sv =====
// ---------------------------------------------------------------------------
// csvt_in_stage: input register of the tokenizer
// Captures one input transfer and holds it until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    input  wire logic           s_tuser,
    input  wire logic           advance,
    output logic                item_valid,
    output csvt_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    csvt_pkg::item_t item_reg;

    // The register may take a new item whenever it is empty or being drained.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op        <= s_tuser;
            item_reg.data_byte <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/csvt_parse.sv =====
// ---------------------------------------------------------------------------
// csvt_parse: tokenizer state and per-byte decision logic
// Keeps the quoting, pending and held-byte state and forms one result.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_parse (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire csvt_pkg::item_t item,
    output logic                res_valid,
    output csvt_pkg::result_t   res
);

    logic       in_quotes_reg,   in_quotes_next;
    logic       quote_pend_reg,  quote_pend_next;
    logic       cr_pend_reg,     cr_pend_next;
    logic       has_content_reg, has_content_next;
    logic       held_valid_reg,  held_valid_next;
    logic [7:0] held_byte_reg,   held_byte_next;

    always_comb begin
        logic       is_lf;
        logic       add_v;
        logic [7:0] add_b;
        logic       fend;
        logic       inq;
        logic       l0_v;
        logic [7:0] l0_b;
        logic       l1_v;
        logic [7:0] l1_b;
        logic [7:0] c;

        c     = item.data_byte;
        is_lf = (item.op == csvt_pkg::OP_EOT) || (c == csvt_pkg::CH_LF);
        add_v = 1'b0;
        add_b = c;
        fend  = 1'b0;
        inq   = in_quotes_reg;

        in_quotes_next   = in_quotes_reg;
        quote_pend_next  = 1'b0;
        cr_pend_next     = 1'b0;
        has_content_next = has_content_reg || cr_pend_reg;

        if (quote_pend_reg && (c == csvt_pkg::CH_QUOTE)) begin
            // A doubled quote inside quotes yields one quote byte.
            has_content_next = 1'b1;
            add_v            = 1'b1;
            add_b            = csvt_pkg::CH_QUOTE;
        end else begin
            if (quote_pend_reg) begin
                inq = 1'b0;
            end
            in_quotes_next = inq;
            if (c == csvt_pkg::CH_CR) begin
                cr_pend_next = 1'b1;
            end else begin
                has_content_next = 1'b1;
                if (inq) begin
                    if (c == csvt_pkg::CH_QUOTE) begin
                        quote_pend_next = 1'b1;
                    end else begin
                        add_v = 1'b1;
                    end
                end else if (c == csvt_pkg::CH_QUOTE) begin
                    in_quotes_next = 1'b1;
                end else if (c == csvt_pkg::CH_COMMA) begin
                    fend = 1'b1;
                end else begin
                    add_v = 1'b1;
                end
            end
        end

        // Ordered byte list: held byte, pending carriage return, new byte.
        // Only the first two survive.
        if (held_valid_reg) begin
            l0_v = 1'b1;
            l0_b = held_byte_reg;
            l1_v = cr_pend_reg || add_v;
            l1_b = cr_pend_reg ? csvt_pkg::CH_CR : add_b;
        end else if (cr_pend_reg) begin
            l0_v = 1'b1;
            l0_b = csvt_pkg::CH_CR;
            l1_v = add_v;
            l1_b = add_b;
        end else begin
            l0_v = add_v;
            l0_b = add_b;
            l1_v = 1'b0;
            l1_b = add_b;
        end

        held_valid_next = l1_v;
        held_byte_next  = l1_v ? l1_b : 8'h00;

        res.has_byte   = l0_v;
        res.out_byte   = l0_v ? l0_b : 8'h00;
        res.field_end  = fend;
        res.record_end = 1'b0;

        if (is_lf) begin
            // Newline or end of text drains the held byte and closes the line.
            res.has_byte     = held_valid_reg;
            res.out_byte     = held_valid_reg ? held_byte_reg : 8'h00;
            res.field_end    = has_content_reg || held_valid_reg;
            res.record_end   = has_content_reg || held_valid_reg;
            in_quotes_next   = 1'b0;
            quote_pend_next  = 1'b0;
            cr_pend_next     = 1'b0;
            has_content_next = 1'b0;
            held_valid_next  = 1'b0;
            held_byte_next   = 8'h00;
        end

        res_valid = res.has_byte || res.field_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg   <= 1'b0;
            quote_pend_reg  <= 1'b0;
            cr_pend_reg     <= 1'b0;
            has_content_reg <= 1'b0;
            held_valid_reg  <= 1'b0;
        end else if (advance) begin
            in_quotes_reg   <= in_quotes_next;
            quote_pend_reg  <= quote_pend_next;
            cr_pend_reg     <= cr_pend_next;
            has_content_reg <= has_content_next;
            held_valid_reg  <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_byte_reg <= held_byte_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csvt_out_stage.sv =====
// ---------------------------------------------------------------------------
// csvt_out_stage: result register of the tokenizer
// Holds one result on the master channel until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_out_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire logic            res_valid,
    input  wire csvt_pkg::result_t res,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    csvt_pkg::result_t res_reg;
    logic              load;

    assign out_free = !valid_reg || m_tready;
    assign load     = advance && res_valid;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tuser  = {res_reg.field_end, res_reg.has_byte};
    assign m_tlast  = res_reg.record_end;

endmodule

`default_nettype wire

// ===== rtl/csv_byte_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// csv_byte_tokenizer_top: streaming CSV tokenizer, one text byte per transfer
// Splits a byte stream into fields and records with quoting support.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel (s_*) carries one text byte per transfer in s_tdata;
//   s_tuser set to 1 marks end of text, which flushes the last line.
//   The master channel (m_*) carries at most one result per input transfer:
//   m_tdata is a field content byte, valid when m_tuser[0] is set; m_tuser[1]
//   says the current field ends after that byte, and m_tlast says the record
//   ends as well. Input bytes that only change the parser state (an opening
//   quote, a carriage return that is still pending, an empty line) give no
//   result transfer.
//   An accepted input transfer passes through the input register and then
//   the result register before its result can be taken on the master
//   channel.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   parser state is a handful of flags and one held byte, updated by logic.
//   When the receiver stalls, the result register holds its transfer and the
//   input register fills; s_tready then drops until m_tready returns.
//   A synchronous low on aresetn empties both registers and clears the
//   parser to the start of a line, outside quotes.
// ---------------------------------------------------------------------------
`default_nettype none

module csv_byte_tokenizer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] op (1 = end of text)
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [0] has_byte, [1] field_end
    output logic            m_tlast    // record_end
);

    logic              item_valid;
    csvt_pkg::item_t   item;
    logic              res_valid;
    csvt_pkg::result_t res;
    logic              out_free;
    logic              advance;

    // An item moves through the parser when the result register can take
    // whatever it produces; items without a result still move on.
    assign advance = item_valid && out_free;

    csvt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    csvt_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    csvt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/csvt_checker.sv =====
// ---------------------------------------------------------------------------
// csvt_checker: port-level checks of the CSV tokenizer
// Watches the result channel for malformed or unstable transfers.
// ---------------------------------------------------------------------------
`default_nettype none

module csvt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // A record end always closes the field too.
    a_rec_has_field: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("record end without field end");

    // Every result carries a byte or a field end.
    a_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || m_tuser[1]))
        else $error("empty result transfer");

    // Without a content byte the data bus reads zero.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("data byte set without has_byte");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Reset empties both registers, so the input side is ready again.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("result valid or input not ready after reset");

endmodule

bind csv_byte_tokenizer_top csvt_checker u_csvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
